// ===== hw/rtl/sfp_pkg.sv =====
`timescale 1ns / 1ps

package sfp_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int STEP_W   = 12;
  localparam int COIL_W   = 4;
  localparam int PHASE_W  = 3;
  localparam int LEVEL_W  = 28;   // Q12.16 filtered level
  localparam int COEF_W   = 16;   // Q0.16 coefficients
  localparam int MUL_A_W  = COEF_W + 1;
  localparam int MUL_B_W  = LEVEL_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int SUM_W    = PROD_W + 1;

  // Config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [COEF_W-1:0] ALPHA_RESET = 16'd6554;
  localparam logic [COEF_W-1:0] SCALE_RESET = 16'd54627;

  typedef enum logic {
    REG_ALPHA = 1'b0,
    REG_SCALE = 1'b1
  } reg_idx_t;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample;
  } job_t;

  typedef struct packed {
    logic [COEF_W-1:0] alpha;
    logic [COEF_W-1:0] scale;
  } cfg_t;

  // Half-step coil sequence, bit0 = first coil
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    unique case (ph)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

// ===== hw/rtl/sfp_ifs.sv =====
`timescale 1ns / 1ps

// Input word: command and converter sample
interface sfp_in_if;
  import sfp_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

// Result word: coil pattern, setpoint and position
interface sfp_out_if;
  import sfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coils;
  logic [STEP_W-1:0] target_step;
  logic [STEP_W-1:0] motor_step;

  modport source (output valid, output coils, output target_step, output motor_step,
                  input ready);
  modport sink   (input valid, input coils, input target_step, input motor_step,
                  output ready);
endinterface

// ===== hw/rtl/sfp_front.sv =====
`timescale 1ns / 1ps

module sfp_front (
  input  logic          clk,
  input  logic          rst_n,
  sfp_in_if.sink        in_item,
  output sfp_pkg::job_t q_job,
  output logic          q_valid,
  input  logic          q_pop
);
  import sfp_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  job_t              job_in;

  // Classify the incoming word
  always_comb begin
    job_in.op     = in_item.cmd ? OP_TICK : OP_SAMPLE;
    job_in.sample = in_item.sample;
  end

  assign in_item.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push          = in_item.valid && in_item.ready;
  assign q_valid       = (count_r != '0);
  assign q_job         = mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (q_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/sfp_back.sv =====
`timescale 1ns / 1ps

module sfp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sfp_pkg::cfg_t cfg,
  input  sfp_pkg::job_t q_job,
  input  logic          q_valid,
  output logic          q_pop,
  sfp_out_if.source     out_item
);
  import sfp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_OLD,
    S_MUL_NEW,
    S_FILT,
    S_MUL_SCALE,
    S_GOAL,
    S_STEP,
    S_FIN
  } state_t;

  state_t              state_r;
  logic [LEVEL_W-1:0]  level_r;
  logic [STEP_W-1:0]   goal_r;
  logic [STEP_W-1:0]   pos_r;
  logic [PHASE_W-1:0]  phase_r;
  logic                first_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [COIL_W-1:0]   coils_r;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   acc_r;
  logic                out_valid_r;
  logic [COIL_W-1:0]   out_coils_r;
  logic [STEP_W-1:0]   out_target_r;
  logic [STEP_W-1:0]   out_pos_r;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;
  logic                out_free;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_free = !out_valid_r || out_item.ready;

  // Shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_MUL_OLD: begin
        mul_a = MUL_A_W'(1 << COEF_W) - {1'b0, cfg.alpha};
        mul_b = level_r;
      end
      S_MUL_NEW: begin
        mul_a = {1'b0, cfg.alpha};
        mul_b = MUL_B_W'(sample_r);
      end
      default: begin
        mul_a = {1'b0, cfg.scale};
        mul_b = level_r;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // EMA: old term plus new term, shifted from Q12.16 to line up with the old term's 32 fraction bits
  assign sum = SUM_W'(acc_r) + SUM_W'({prod_r, {COEF_W{1'b0}}});

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      goal_r      <= '0;
      pos_r       <= '0;
      phase_r     <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // S_FIN reloads the result register itself
      if (out_valid_r && out_item.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            sample_r <= q_job.sample;
            coils_r  <= coil_pattern(phase_r);
            state_r  <= (q_job.op == OP_TICK) ? S_STEP : S_MUL_OLD;
          end
        end
        S_MUL_OLD: begin
          prod_r  <= prod;
          state_r <= S_MUL_NEW;
        end
        S_MUL_NEW: begin
          acc_r   <= prod_r;
          prod_r  <= prod;
          state_r <= S_FILT;
        end
        S_FILT: begin
          level_r <= sum[COEF_W +: LEVEL_W];
          state_r <= S_MUL_SCALE;
        end
        S_MUL_SCALE: begin
          prod_r  <= prod;
          state_r <= S_GOAL;
        end
        S_GOAL: begin
          goal_r <= prod_r[2*COEF_W +: STEP_W];
          if (first_r) begin
            pos_r   <= prod_r[2*COEF_W +: STEP_W];
            first_r <= 1'b0;
          end
          state_r <= S_FIN;
        end
        S_STEP: begin
          // One half step toward the setpoint
          if (goal_r > pos_r) begin
            phase_r <= phase_r + 1'b1;
            pos_r   <= pos_r + 1'b1;
          end else if (goal_r < pos_r) begin
            phase_r <= phase_r - 1'b1;
            pos_r   <= pos_r - 1'b1;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_coils_r  <= coils_r;
            out_target_r <= goal_r;
            out_pos_r    <= pos_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.coils       = out_coils_r;
  assign out_item.target_step = out_target_r;
  assign out_item.motor_step  = out_pos_r;

endmodule

// ===== hw/rtl/stepper_position_follower.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// in_item   in   valid/ready           cmd, sample
// out_item  out  valid/ready           coils, target_step, motor_step
// config    in   APB psel/penable      filter_alpha @0x0, setpoint_scale @0x4
//
// Ticks pass S_IDLE, S_STEP, S_FIN; samples pass S_IDLE, S_MUL_OLD, S_MUL_NEW,
// S_FILT, S_MUL_SCALE, S_GOAL, S_FIN, using the single shared 17x28 multiplier
// three times. A 2-word queue lets the input accept while the back end works.
// Synchronous active-low reset clears the queue, filter, phase and position.
// A stalled output holds its word; the back end waits in its final state.
module stepper_position_follower (
  input  logic                         clk,
  input  logic                         rst_n,
  sfp_in_if.sink                       in_item,
  sfp_out_if.source                    out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [sfp_pkg::PDATA_W-1:0]  pwdata,
  output logic [sfp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import sfp_pkg::*;

  logic [COEF_W-1:0] alpha_r;
  logic [COEF_W-1:0] scale_r;
  cfg_t              cfg;
  job_t              q_job;
  logic              q_valid;
  logic              q_pop;
  logic              cfg_wr;
  reg_idx_t          reg_idx;

  // Register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ALPHA: alpha_r <= pwdata[COEF_W-1:0];
        REG_SCALE: scale_r <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALPHA: prdata = PDATA_W'(alpha_r);
      REG_SCALE: prdata = PDATA_W'(scale_r);
      default:   prdata = '0;
    endcase
  end

  assign cfg.alpha = alpha_r;
  assign cfg.scale = scale_r;

  sfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .q_job   (q_job),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  sfp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_job    (q_job),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_item (out_item)
  );

  // Back end only pops a word that is present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // One word in flight at a time in the back end
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end popped on consecutive cycles");

  // Setpoint never reaches full scale
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> (out_item.target_step != {STEP_W{1'b1}}))
    else $error("setpoint out of range");

endmodule

// ===== tb/sv/tb_stepper_position_follower.sv =====
`timescale 1ns / 1ps

module tb_stepper_position_follower;
  import sfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int PRINT_CAP      = 100;

  // Half-step coil sequence, phase 0 in the low nibble
  localparam logic [31:0] HALF_STEP = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic [STEP_W-1:0] target;
    logic [STEP_W-1:0] motor;
  } drive_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  sfp_in_if  in_if ();
  sfp_out_if out_if ();

  stepper_position_follower i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Follower model state and its copy of the registers
  logic [COEF_W-1:0]  mdl_alpha;
  logic [COEF_W-1:0]  mdl_scale;
  logic [LEVEL_W-1:0] mdl_level;
  logic [STEP_W-1:0]  mdl_goal;
  logic [STEP_W-1:0]  mdl_pos;
  logic [PHASE_W-1:0] mdl_phase;
  logic               mdl_first;

  drive_t pending_drive[$];

  int  mismatches;
  int  words_sent;
  int  ticks_sent;
  int  results_seen;
  int  settings_used;
  int  idle_count;
  bit  gaps_on;
  logic [SAMPLE_W-1:0] last_raw;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  // Advance the model by one word and return the drive it should produce
  function automatic drive_t follow_motor(input op_t op, input logic [SAMPLE_W-1:0] raw);
    drive_t     d;
    logic [63:0] acc;
    logic [63:0] prod;
    d.coils = HALF_STEP[mdl_phase*4 +: 4];
    if (op == OP_SAMPLE) begin
      acc = 64'(mdl_alpha) * {36'd0, raw, 16'd0} +
            (64'd65536 - 64'(mdl_alpha)) * 64'(mdl_level);
      mdl_level = acc[43:16];
      prod = 64'(mdl_level) * 64'(mdl_scale);
      mdl_goal = prod[43:32];
      if (mdl_first) begin
        mdl_pos   = mdl_goal;
        mdl_first = 1'b0;
      end
    end else if (mdl_goal > mdl_pos) begin
      mdl_phase = mdl_phase + 1'b1;
      mdl_pos   = mdl_pos + 1'b1;
    end else if (mdl_goal < mdl_pos) begin
      mdl_phase = mdl_phase - 1'b1;
      mdl_pos   = mdl_pos - 1'b1;
    end
    d.target = mdl_goal;
    d.motor  = mdl_pos;
    return d;
  endfunction

  // Send one word; returns at the edge where it is accepted, valid still high
  task automatic send_word(input op_t op, input logic [SAMPLE_W-1:0] raw);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 21) begin
      gap = $urandom_range(4, 1);
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid  = 1'b1;
    in_if.cmd    = op;
    in_if.sample = raw;
    do @(posedge clk); while (!in_if.ready);
    pending_drive.push_back(follow_motor(op, raw));
    words_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  // Stop sending and wait for every expected word to come back
  task automatic drain_results();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      if (idx == REG_ALPHA) mdl_alpha = data[COEF_W-1:0];
      else mdl_scale = data[COEF_W-1:0];
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_register(input reg_idx_t idx, input logic [COEF_W-1:0] want);
    logic [PDATA_W-1:0] rd;
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== PDATA_W'(want)) report_mismatch(idx == REG_ALPHA ? "alpha readback" :
                                               "scale readback", rd, want);
  endtask

  // Write both registers (block idle), then read them back
  task automatic set_filter(input logic [PDATA_W-1:0] alpha, input logic [PDATA_W-1:0] scale);
    logic [PDATA_W-1:0] rd;
    drain_results();
    apb_access(REG_ALPHA, 1'b1, alpha, rd);
    apb_access(REG_SCALE, 1'b1, scale, rd);
    check_register(REG_ALPHA, alpha[COEF_W-1:0]);
    check_register(REG_SCALE, scale[COEF_W-1:0]);
    settings_used++;
  endtask

  // Result checker
  always @(posedge clk) begin
    drive_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_drive.size() == 0) begin
        report_mismatch("unexpected word", out_if.motor_step, -1);
      end else begin
        want = pending_drive.pop_front();
        if (out_if.coils !== want.coils) report_mismatch("coils", out_if.coils, want.coils);
        if (out_if.target_step !== want.target)
          report_mismatch("target_step", out_if.target_step, want.target);
        if (out_if.motor_step !== want.motor)
          report_mismatch("motor_step", out_if.motor_step, want.motor);
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    out_if.ready <= gaps_on ? ($urandom_range(99) >= 21) : 1'b1;
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel || !rst_n)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_register_defaults();
    check_register(REG_ALPHA, ALPHA_RESET);
    check_register(REG_SCALE, SCALE_RESET);
  endtask

  task automatic test_directed_cases();
    // tick before any sample: goal and position both zero
    send_word(OP_TICK, 12'hFFF);
    // first sample moves position straight to the setpoint
    send_word(OP_SAMPLE, 12'hFFF);
    send_word(OP_TICK, 12'h000);
    // lower sample pulls the goal down; steps down wrap phase 0 -> 7
    send_word(OP_SAMPLE, 12'h000);
    repeat (3) send_word(OP_TICK, 12'h000);
    // full alpha and scale: goal jumps near the top, steps up wrap 7 -> 0
    set_filter(32'h0000_FFFF, 32'h0000_FFFF);
    send_word(OP_SAMPLE, 12'hFFF);
    repeat (3) send_word(OP_TICK, 12'hA5A);
    send_word(OP_SAMPLE, 12'h000);
    send_word(OP_TICK, 12'h5A5);
    // alpha zero: filtered level frozen
    set_filter(32'h0000_0000, 32'h0000_FFFF);
    send_word(OP_SAMPLE, 12'h555);
    send_word(OP_TICK, 12'h000);
    // scale zero: goal drops to zero
    set_filter(32'hFFFF_8000, 32'h0000_0000);
    send_word(OP_SAMPLE, 12'hAAA);
    repeat (2) send_word(OP_TICK, 12'hFFF);
    last_raw = 12'hAAA;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int near;
    case ($urandom_range(3))
      0: return SAMPLE_W'($urandom);
      1: return $urandom_range(1) ? 12'hFFF : 12'h000;
      default: begin
        near = int'(last_raw) + int'($urandom_range(80)) - 40;
        if (near < 0) near = 0;
        if (near > 4095) near = 4095;
        return SAMPLE_W'(near);
      end
    endcase
  endfunction

  // One filter setting, mostly ticks chasing samples that wander locally or jump to random or full-scale values
  task automatic track_phase(input logic [PDATA_W-1:0] alpha, input logic [PDATA_W-1:0] scale,
                             input int count, input bit pause_mid);
    logic [SAMPLE_W-1:0] raw;
    set_filter(alpha, scale);
    for (int k = 0; k < count; k++) begin
      if (pause_mid && k == count / 2) drain_results();
      if ($urandom_range(99) < 65) begin
        send_word(OP_TICK, SAMPLE_W'($urandom));
      end else begin
        raw = pick_sample();
        last_raw = raw;
        send_word(OP_SAMPLE, raw);
      end
    end
  endtask

  task automatic test_random_tracking();
    track_phase(32'(ALPHA_RESET), 32'(SCALE_RESET), 250, 1'b1);
    gaps_on = 1'b0;
    track_phase(32'h0000_FFFF, 32'h0000_FFFF, 250, 1'b0);
    gaps_on = 1'b1;
    track_phase(32'h0000_0000, 32'($urandom_range(65535)), 250, 1'b0);
    track_phase(32'h0000_0001, 32'h0000_0001, 250, 1'b1);
    track_phase($urandom, $urandom, 250, 1'b0);
    track_phase(32'h0000_8000, 32'h0000_FFFF, 250, 1'b0);
  endtask

  task automatic test_wrapup();
    drain_results();
    repeat (20) @(posedge clk);
    if (pending_drive.size() != 0)
      report_mismatch("words never returned", 0, pending_drive.size());
  endtask

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_if.valid   = 1'b0;
    in_if.cmd     = OP_SAMPLE;
    in_if.sample  = '0;
    gaps_on       = 1'b1;
    mismatches    = 0;
    words_sent    = 0;
    ticks_sent    = 0;
    results_seen  = 0;
    settings_used = 0;
    last_raw      = '0;
    mdl_alpha     = ALPHA_RESET;
    mdl_scale     = SCALE_RESET;
    mdl_level     = '0;
    mdl_goal      = '0;
    mdl_pos       = '0;
    mdl_phase     = '0;
    mdl_first     = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_defaults();
    test_directed_cases();
    test_random_tracking();
    test_wrapup();

    $display("covered %0d words (%0d ticks, %0d samples) over %0d filter settings",
             words_sent, ticks_sent, words_sent - ticks_sent, settings_used);
    $display("checked %0d result words, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
